// ----- design/mdtp_pkg.sv -----
// shared types and constants for the multichannel dac table player
// no dependencies; imported by mdtp_ctrl, mdtp_dpath and the top level
package mdtp_pkg;

	// input op codes
	localparam logic [2:0] OP_LOAD  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_TICK  = 3'd3;
	localparam logic [2:0] OP_DONE  = 3'd4;
	localparam logic [2:0] OP_ERROR = 3'd5;

	// configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 52;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MAP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_COMMAND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_BASE = 3'd4;

	// configuration reset values
	localparam logic [10:0] POINT_COUNT_RST   = 11'd1;
	localparam logic [3:0]  CHANNEL_COUNT_RST = 4'd1;
	localparam logic [5:0]  REGISTER_BASE_RST = 6'd16;

	// dac register address field of the command byte
	localparam logic [5:0] CMD_ADDR_MASK = 6'h3F;

	typedef struct packed {
		logic [2:0]  op;
		logic [9:0]  table_index;
		logic [15:0] dac_code;
	} cmd_t;

	typedef struct packed {
		logic        frame_valid;
		logic [23:0] frame;
		logic        last;
		logic        latch_pulse;
		logic        overrun;
		logic        running;
		logic        busy_res;
		logic [31:0] sample_count;
		logic [31:0] error_count;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic       accept;
		logic       emit;
		logic       last;
		logic [3:0] slot;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       tick_go;
		logic [3:0] chan_last;
	} dp_stat_t;

endpackage

// ----- design/multichannel_dac_table_player_core.sv -----
// top level of the multichannel dac table player
// depends on mdtp_pkg, mdtp_ctrl and mdtp_dpath
//
//   channel   ports                              handshake
//   ------    ---------------------------------  ------------------------------
//   input     start, busy, cmd (cmd_t)           taken when start and not busy
//   result    result_valid, result (result_t)    one-cycle strobe, never stalled
//   config    cfg_we, cfg_index, cfg_data        written when cfg_we is high
//
// a tick that sends frames reads the table entry into a holding register, then sends
//   one frame a cycle, for each of the n configured channels (up to thirteen by
//   default), through the single result port; busy is high during the frames
// every other item sends no frames; its status result follows in the next cycle
// results are registered and appear in the cycle after the cycle that produced them
// reset clears the fsm, playback state, counters and config registers; the
//   code table is not cleared and entries read before being loaded are garbage
module multichannel_dac_table_player_core #(
	parameter int TABLE_DEPTH  = 1024,
	parameter int MAX_CHANNELS = 13,
	parameter int CELL_COUNT   = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// item channel
	input  logic                             start,
	output logic                             busy,
	input  mdtp_pkg::cmd_t                   cmd,
	// result channel
	output logic                             result_valid,
	output mdtp_pkg::result_t                result,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [mdtp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mdtp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mdtp_pkg::*;

	// command and status between controller and datapath
	ctl_cmd_t ctl;
	dp_stat_t stat;

	// controller: accepts items and walks channel slots during a tick burst
	mdtp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	// datapath: table memory, playback state, frame assembly, result register
	mdtp_dpath #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.MAX_CHANNELS (MAX_CHANNELS),
		.CELL_COUNT   (CELL_COUNT)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.ctl          (ctl),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ----- design/mdtp_ctrl.sv -----
// controller fsm: accepts items, sequences one frame per channel slot
// depends on mdtp_pkg
module mdtp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mdtp_pkg::dp_stat_t stat,
	output logic              busy,
	output mdtp_pkg::ctl_cmd_t ctl
);
	import mdtp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t     state_q;
	logic [3:0] slot_q;

	assign busy       = (state_q != ST_IDLE);
	assign ctl.accept = start && (state_q == ST_IDLE);
	assign ctl.emit   = (state_q == ST_EMIT);
	assign ctl.slot   = slot_q;
	assign ctl.last   = (slot_q == stat.chan_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					slot_q <= '0;
					if (ctl.accept && stat.tick_go) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (ctl.last) begin
						state_q <= ST_IDLE;
						slot_q  <= '0;
					end else begin
						slot_q <= slot_q + 4'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					slot_q  <= '0;
				end
			endcase
		end
	end

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (slot_q <= stat.chan_last))
		else $error("slot counter past channel count");

	a_last_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && ctl.last) |=> (state_q == ST_IDLE))
		else $error("burst did not end after last frame");

endmodule

// ----- design/mdtp_dpath.sv -----
// datapath: config registers, code table memory, playback state, result register
// depends on mdtp_pkg
module mdtp_dpath #(
	parameter int TABLE_DEPTH  = 1024,
	parameter int MAX_CHANNELS = 13,
	parameter int CELL_COUNT   = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mdtp_pkg::cmd_t                   cmd,
	input  mdtp_pkg::ctl_cmd_t               ctl,
	input  logic                             cfg_we,
	input  logic [mdtp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mdtp_pkg::CFG_DATA_W-1:0]  cfg_data,
	output mdtp_pkg::dp_stat_t               stat,
	output logic                             result_valid,
	output mdtp_pkg::result_t                result
);
	import mdtp_pkg::*;

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int PCW = (AW + 1 > 11) ? AW + 1 : 11;

	// configuration
	logic [10:0] point_count_q;
	logic [3:0]  channel_count_q;
	logic [51:0] channel_map_q;
	logic [7:0]  write_command_q;
	logic [5:0]  register_base_q;

	// playback state
	logic [AW-1:0] point_q;
	logic          running_q;
	logic          busy_q;
	logic [31:0]   samples_q;
	logic [31:0]   errors_q;

	logic [15:0] code_mem [TABLE_DEPTH];
	logic [15:0] code_q;

	logic          res_valid_q;
	result_t       res_q;

	// clamped counts and point selection
	logic [PCW-1:0] pc_ext, pc_eff, pt_next;
	logic [AW-1:0]  pt, point_nxt;
	logic [4:0]     cc_ext;
	logic [3:0]     cc_eff;

	always_comb begin
		pc_ext = PCW'(point_count_q);
		if (pc_ext == '0) begin
			pc_eff = PCW'(1);
		end else if (pc_ext > PCW'(TABLE_DEPTH)) begin
			pc_eff = PCW'(TABLE_DEPTH);
		end else begin
			pc_eff = pc_ext;
		end
		pt        = (PCW'(point_q) < pc_eff) ? point_q : '0;
		pt_next   = PCW'(pt) + PCW'(1);
		point_nxt = (pt_next >= pc_eff) ? '0 : pt_next[AW-1:0];

		cc_ext = 5'(channel_count_q);
		if (cc_ext == '0) begin
			cc_eff = 4'd1;
		end else if (cc_ext > 5'(MAX_CHANNELS)) begin
			cc_eff = 4'(MAX_CHANNELS);
		end else begin
			cc_eff = channel_count_q;
		end
	end

	assign stat.chan_last = cc_eff - 4'd1;
	assign stat.tick_go   = (cmd.op == OP_TICK) && running_q && !busy_q;

	// next state of one accepted item
	logic        running_d, busy_d, latch, over, load_we;
	logic [31:0] samples_d, errors_d;
	logic [AW-1:0] point_d;
	logic [16:0] idx_ext;

	assign idx_ext = 17'(cmd.table_index);

	always_comb begin
		running_d = running_q;
		busy_d    = busy_q;
		samples_d = samples_q;
		errors_d  = errors_q;
		point_d   = point_q;
		latch     = 1'b0;
		over      = 1'b0;
		load_we   = 1'b0;
		case (cmd.op)
			OP_LOAD: begin
				load_we = !running_q && (idx_ext < 17'(TABLE_DEPTH));
			end
			OP_START: begin
				point_d   = '0;
				samples_d = '0;
				errors_d  = '0;
				busy_d    = 1'b0;
				running_d = 1'b1;
			end
			OP_STOP: begin
				running_d = 1'b0;
				busy_d    = 1'b0;
			end
			OP_TICK: begin
				if (running_q && busy_q) begin
					errors_d = errors_q + 32'd1;
					over     = 1'b1;
				end else if (running_q) begin
					busy_d  = 1'b1;
					point_d = point_nxt;
				end
			end
			OP_DONE: begin
				if (running_q && busy_q) begin
					busy_d    = 1'b0;
					latch     = 1'b1;
					samples_d = samples_q + 32'd1;
				end
			end
			OP_ERROR: begin
				errors_d  = errors_q + 32'd1;
				running_d = 1'b0;
				busy_d    = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// code table: one write port for loads, registered read whenever an item is accepted
	always_ff @(posedge clk) begin
		if (ctl.accept && load_we) begin
			code_mem[idx_ext[AW-1:0]] <= cmd.dac_code;
		end
		if (ctl.accept) begin
			code_q <= code_mem[pt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q   <= POINT_COUNT_RST;
			channel_count_q <= CHANNEL_COUNT_RST;
			channel_map_q   <= '0;
			write_command_q <= '0;
			register_base_q <= REGISTER_BASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POINT_COUNT:   point_count_q   <= cfg_data[10:0];
				CFG_CHANNEL_COUNT: channel_count_q <= cfg_data[3:0];
				CFG_CHANNEL_MAP:   channel_map_q   <= cfg_data[51:0];
				CFG_WRITE_COMMAND: write_command_q <= cfg_data[7:0];
				CFG_REGISTER_BASE: register_base_q <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_q   <= '0;
			running_q <= 1'b0;
			busy_q    <= 1'b0;
			samples_q <= '0;
			errors_q  <= '0;
		end else if (ctl.accept) begin
			point_q   <= point_d;
			running_q <= running_d;
			busy_q    <= busy_d;
			samples_q <= samples_d;
			errors_q  <= errors_d;
		end
	end

	// frame for the current channel slot
	logic [63:0] map_ext;
	logic [3:0]  ch_raw, ch;
	logic [6:0]  addr_sum;
	logic [7:0]  cmd_byte;

	always_comb begin
		map_ext  = {12'd0, channel_map_q};
		ch_raw   = map_ext[{ctl.slot, 2'b00} +: 4];
		ch       = (5'(ch_raw) >= 5'(CELL_COUNT)) ? 4'(CELL_COUNT - 1) : ch_raw;
		addr_sum = 7'(register_base_q) + 7'(ch);
		cmd_byte = write_command_q | {2'b00, addr_sum[5:0] & CMD_ADDR_MASK};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (ctl.accept && !stat.tick_go) || ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			res_q.frame_valid  <= 1'b1;
			res_q.frame        <= {cmd_byte, code_q};
			res_q.last         <= ctl.last;
			res_q.latch_pulse  <= 1'b0;
			res_q.overrun      <= 1'b0;
			res_q.running      <= running_q;
			res_q.busy_res     <= busy_q;
			res_q.sample_count <= samples_q;
			res_q.error_count  <= errors_q;
		end else if (ctl.accept) begin
			res_q.frame_valid  <= 1'b0;
			res_q.frame        <= '0;
			res_q.last         <= 1'b1;
			res_q.latch_pulse  <= latch;
			res_q.overrun      <= over;
			res_q.running      <= running_d;
			res_q.busy_res     <= busy_d;
			res_q.sample_count <= samples_d;
			res_q.error_count  <= errors_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_tick_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.accept && stat.tick_go) |=> (busy_q && running_q))
		else $error("tick burst started without busy and running");

	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> $past(ctl.accept || ctl.emit))
		else $error("result strobe without accepted item or frame");

	a_emit_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (busy_q && running_q))
		else $error("frame emitted while not in a transfer");

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for multichannel_dac_table_player_core: directed and random items,
// every result checked against a state-keeping predictor of the table player
// depends on mdtp_pkg and the design sources only
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mdtp_pkg::*;

	// sizes of the instance as built with its default parameters
	localparam int TBL_DEPTH = 1024;
	localparam int CHAN_MAX  = 13;

	// watchdog, far above the slowest legal run
	localparam int unsigned CYCLE_LIMIT = 400000;

	// op codes the block has no meaning for
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	// first register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	cmd_t                  cmd;
	logic                  result_valid;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	multichannel_dac_table_player_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// ------------------------------------------------------------------
	// mirror of the player state and its registers
	// ------------------------------------------------------------------
	logic [15:0] code_tbl [TBL_DEPTH];
	bit          loaded   [TBL_DEPTH];   // entries that may be read by a tick
	int          pt_idx;
	bit          play_on;
	bit          xfer_busy;
	logic [31:0] n_samples;
	logic [31:0] n_errors;

	logic [10:0] reg_points;
	logic [3:0]  reg_chans;
	logic [51:0] reg_map;
	logic [7:0]  reg_wcmd;
	logic [5:0]  reg_base;

	// results still owed by the block, oldest first
	result_t frames_due[$];

	int unsigned mism_cnt;
	int unsigned acted_items;   // items that changed state or sent frames
	int unsigned cycle_cnt;
	bit          gaps_on;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [CFG_DATA_W-1:0] wide_random();
		return {20'($urandom), $urandom};
	endfunction

	// point count as the block uses it: zero reads as one, clamp at table depth
	function automatic int points_in_use();
		int n;
		n = int'(reg_points);
		if (n == 0) n = 1;
		if (n > TBL_DEPTH) n = TBL_DEPTH;
		return n;
	endfunction

	// table point the next tick will read; an index stranded past the count
	// (count lowered while running) falls back to point zero
	function automatic int next_point();
		return (pt_idx < points_in_use()) ? pt_idx : 0;
	endfunction

	// a tick that would read a never-loaded entry must not be sent
	function automatic bit tick_reads_unloaded();
		int p;
		p = next_point();
		return play_on && !xfer_busy && !loaded[p];
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mism_cnt++;
		if (mism_cnt <= 60)
			$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(name, got, want);
	endtask

	// ------------------------------------------------------------------
	// predictor: applies one accepted item to the mirror and queues the
	// results it must produce
	// ------------------------------------------------------------------
	task automatic predict_dac_results(input cmd_t c, output bit acted);
		result_t     r;
		int          npts;
		int          nch;
		int          pt;
		logic [15:0] code;
		logic [3:0]  ch;
		logic [5:0]  addr;
		logic [7:0]  cbyte;
		bit          latch;
		bit          over;
		bit          framed;
		latch  = 1'b0;
		over   = 1'b0;
		framed = 1'b0;
		acted  = 1'b1;
		case (c.op)
			OP_LOAD: begin
				// the table is frozen while playing
				if (!play_on) begin
					code_tbl[c.table_index] = c.dac_code;
					loaded[c.table_index]   = 1'b1;
				end else begin
					acted = 1'b0;
				end
			end
			OP_START: begin
				// also a restart when already playing
				pt_idx    = 0;
				n_samples = '0;
				n_errors  = '0;
				xfer_busy = 1'b0;
				play_on   = 1'b1;
			end
			OP_STOP: begin
				acted     = play_on || xfer_busy;
				play_on   = 1'b0;
				xfer_busy = 1'b0;
			end
			OP_TICK: begin
				if (!play_on) begin
					acted = 1'b0;
				end else if (xfer_busy) begin
					// previous transfer still in flight
					n_errors = n_errors + 32'd1;
					over     = 1'b1;
				end else begin
					npts = points_in_use();
					nch  = int'(reg_chans);
					if (nch == 0) nch = 1;
					if (nch > CHAN_MAX) nch = CHAN_MAX;
					pt        = next_point();
					code      = code_tbl[pt];
					xfer_busy = 1'b1;
					pt_idx    = pt + 1;
					if (pt_idx >= npts) pt_idx = 0;
					// one frame per driven channel, all with the same code; a 4-bit
					// channel number never reaches the cell count, so no clamp
					for (int k = 0; k < nch; k++) begin
						ch             = reg_map[4*k +: 4];
						addr           = reg_base + {2'b00, ch};
						cbyte          = reg_wcmd | {2'b00, addr};
						r              = '0;
						r.frame_valid  = 1'b1;
						r.frame        = {cbyte, code};
						r.last         = (k == nch - 1);
						r.running      = play_on;
						r.busy_res     = xfer_busy;
						r.sample_count = n_samples;
						r.error_count  = n_errors;
						frames_due.push_back(r);
					end
					framed = 1'b1;
				end
			end
			OP_DONE: begin
				if (play_on && xfer_busy) begin
					xfer_busy = 1'b0;
					latch     = 1'b1;
					n_samples = n_samples + 32'd1;
				end else begin
					acted = 1'b0;
				end
			end
			OP_ERROR: begin
				// counted even when already stopped
				n_errors  = n_errors + 32'd1;
				play_on   = 1'b0;
				xfer_busy = 1'b0;
			end
			default: acted = 1'b0;
		endcase
		if (!framed) begin
			r              = '0;
			r.last         = 1'b1;
			r.latch_pulse  = latch;
			r.overrun      = over;
			r.running      = play_on;
			r.busy_res     = xfer_busy;
			r.sample_count = n_samples;
			r.error_count  = n_errors;
			frames_due.push_back(r);
		end
	endtask

	// ------------------------------------------------------------------
	// result checker: every strobe is matched against the oldest entry
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n === 1'b1 && result_valid !== 1'b0) begin
			if (frames_due.size() == 0) begin
				report_mismatch("result with none expected, frame", 32'(result.frame), '0);
			end else begin
				want = frames_due.pop_front();
				check_field("frame_valid", 32'(result.frame_valid), 32'(want.frame_valid));
				check_field("frame", 32'(result.frame), 32'(want.frame));
				check_field("last", 32'(result.last), 32'(want.last));
				check_field("latch_pulse", 32'(result.latch_pulse), 32'(want.latch_pulse));
				check_field("overrun", 32'(result.overrun), 32'(want.overrun));
				check_field("running", 32'(result.running), 32'(want.running));
				check_field("busy_res", 32'(result.busy_res), 32'(want.busy_res));
				check_field("sample_count", result.sample_count, want.sample_count);
				check_field("error_count", result.error_count, want.error_count);
			end
		end
	end

	// ------------------------------------------------------------------
	// item driver: optional idle burst, then hold start until accepted
	// ------------------------------------------------------------------
	task automatic send_item(input logic [2:0] op, input logic [9:0] idx,
			input logic [15:0] code);
		cmd_t c;
		bit   acted;
		int   gap;
		c.op          = op;
		c.table_index = idx;
		c.dac_code    = code;
		if (gaps_on && $urandom_range(0, 99) < 20) begin
			gap = $urandom_range(1, 15);
			// junk on the command bus while start is low
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
				cmd   <= 29'($urandom);
			end
		end
		@(negedge clk);
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy !== 1'b0);
		predict_dac_results(c, acted);
		if (acted) acted_items++;
	endtask

	// drop start and wait for every owed result, then a few spare cycles
	task automatic settle_block();
		int waited;
		@(negedge clk);
		start  <= 1'b0;
		waited = 0;
		while (frames_due.size() != 0 && waited < 400) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (frames_due.size() != 0) begin
			report_mismatch("results never arrived, count", 32'(frames_due.size()), '0);
			frames_due.delete();
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_POINT_COUNT:   reg_points = data[10:0];
			CFG_CHANNEL_COUNT: reg_chans  = data[3:0];
			CFG_CHANNEL_MAP:   reg_map    = data[51:0];
			CFG_WRITE_COMMAND: reg_wcmd   = data[7:0];
			CFG_REGISTER_BASE: reg_base   = data[5:0];
			default: ;
		endcase
	endtask

	// load the first points of the period (those not yet loaded, and some
	// again) plus a few anywhere in the table; only meaningful when stopped
	task automatic fill_table();
		int lim;
		lim = points_in_use();
		if (lim > 20) lim = 20;
		for (int i = 0; i < lim; i++)
			if (!loaded[i] || $urandom_range(0, 3) == 0)
				send_item(OP_LOAD, 10'(i), 16'($urandom));
		repeat ($urandom_range(1, 5))
			send_item(OP_LOAD, 10'($urandom), 16'($urandom));
	endtask

	// one random item, weighted toward the normal tick / transfer-done cycle
	task automatic play_step();
		int         r;
		logic [2:0] op;
		r = $urandom_range(0, 99);
		if (!play_on) begin
			if (r < 60)      op = OP_START;
			else if (r < 75) op = OP_LOAD;
			else if (r < 80) op = OP_TICK;
			else if (r < 85) op = OP_DONE;
			else if (r < 93) op = OP_ERROR;
			else             op = r[0] ? OP_SPARE_LO : OP_SPARE_HI;
		end else begin
			if (r < 62)      op = xfer_busy ? OP_DONE : OP_TICK;
			else if (r < 70) op = OP_TICK;
			else if (r < 75) op = OP_DONE;
			else if (r < 79) op = OP_LOAD;
			else if (r < 83) op = OP_START;
			else if (r < 87) op = OP_STOP;
			else if (r < 91) op = OP_ERROR;
			else if (r < 94) op = r[0] ? OP_SPARE_LO : OP_SPARE_HI;
			else             op = xfer_busy ? OP_DONE : OP_TICK;
		end
		// never let a tick read a table entry that was never loaded
		if (op == OP_TICK && tick_reads_unloaded()) op = OP_STOP;
		send_item(op, 10'($urandom), 16'($urandom));
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset register values, every op, the ignored and error cases
	task automatic test_default_registers();
		send_item(OP_LOAD, 10'd0, 16'hFFFF);
		send_item(OP_LOAD, 10'd1023, 16'h0000);
		send_item(OP_TICK, 10'($urandom), 16'($urandom));      // stopped: ignored
		send_item(OP_DONE, 10'($urandom), 16'($urandom));      // stopped: no latch
		send_item(OP_SPARE_LO, 10'($urandom), 16'($urandom));
		send_item(OP_SPARE_HI, 10'($urandom), 16'($urandom));
		send_item(OP_START, 10'($urandom), 16'($urandom));
		send_item(OP_TICK, 10'($urandom), 16'($urandom));      // one frame, address 16
		send_item(OP_TICK, 10'($urandom), 16'($urandom));      // overrun
		send_item(OP_DONE, 10'($urandom), 16'($urandom));      // latch, one sample
		send_item(OP_DONE, 10'($urandom), 16'($urandom));      // not busy: ignored
		send_item(OP_LOAD, 10'd5, 16'h5A5A);                   // running: ignored
		send_item(OP_ERROR, 10'($urandom), 16'($urandom));     // counts and stops
		send_item(OP_ERROR, 10'($urandom), 16'($urandom));     // stopped: still counted
	endtask

	// oversized counts clamp, all-ones map, address wraps past 63, restart
	task automatic test_register_extremes();
		settle_block();
		write_reg(CFG_POINT_COUNT, 52'd2047);
		write_reg(CFG_CHANNEL_COUNT, 52'd15);
		write_reg(CFG_CHANNEL_MAP, {CFG_DATA_W{1'b1}});
		write_reg(CFG_WRITE_COMMAND, 52'hFF);
		write_reg(CFG_REGISTER_BASE, 52'd63);
		send_item(OP_START, 10'($urandom), 16'($urandom));
		send_item(OP_TICK, 10'($urandom), 16'($urandom));      // thirteen frames
		send_item(OP_DONE, 10'($urandom), 16'($urandom));
		send_item(OP_START, 10'($urandom), 16'($urandom));     // restart while running
		send_item(OP_TICK, 10'($urandom), 16'($urandom));      // back at point zero
		send_item(OP_STOP, 10'($urandom), 16'($urandom));      // keeps the counters
	endtask

	// zero counts read as one, then the point count lowered under a running
	// index so the next tick falls back to point zero
	task automatic test_small_config();
		settle_block();
		write_reg(CFG_POINT_COUNT, 52'd0);
		write_reg(CFG_CHANNEL_COUNT, 52'd0);
		write_reg(CFG_CHANNEL_MAP, 52'hEDCBA9876543F);
		write_reg(CFG_WRITE_COMMAND, 52'h80);
		write_reg(CFG_REGISTER_BASE, 52'd0);
		send_item(OP_LOAD, 10'd1, 16'h8001);
		send_item(OP_START, 10'($urandom), 16'($urandom));
		send_item(OP_TICK, 10'($urandom), 16'($urandom));
		send_item(OP_DONE, 10'($urandom), 16'($urandom));
		settle_block();
		write_reg(CFG_POINT_COUNT, 52'd2);
		send_item(OP_TICK, 10'($urandom), 16'($urandom));      // point 0, index moves to 1
		send_item(OP_DONE, 10'($urandom), 16'($urandom));
		settle_block();
		write_reg(CFG_POINT_COUNT, 52'd1);
		send_item(OP_TICK, 10'($urandom), 16'($urandom));      // index past count
	endtask

	// phases of random registers and mostly well-formed playback
	task automatic test_random_playback();
		int unsigned          goal;
		int                   r;
		logic [CFG_DATA_W-1:0] d;
		goal = acted_items + 320;
		while (acted_items < goal) begin
			settle_block();
			// some phases run without any idle cycles
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 1) == 1) begin
				// junk above the register width in some writes
				d = ($urandom_range(0, 3) == 0) ? wide_random() : '0;
				r = $urandom_range(0, 99);
				if (r < 55)      d[10:0] = 11'($urandom_range(1, 12));
				else if (r < 70) d[10:0] = 11'($urandom_range(13, 64));
				else if (r < 80) d[10:0] = 11'd1024;
				else if (r < 85) d[10:0] = 11'd0;
				else if (r < 92) d[10:0] = 11'($urandom_range(1025, 2047));
				else             d[10:0] = 11'($urandom);
				write_reg(CFG_POINT_COUNT, d);
			end
			if ($urandom_range(0, 1) == 1) begin
				d = ($urandom_range(0, 3) == 0) ? wide_random() : '0;
				r = $urandom_range(0, 99);
				if (r < 50)      d[3:0] = 4'($urandom_range(1, 4));
				else if (r < 70) d[3:0] = 4'($urandom_range(5, 13));
				else if (r < 80) d[3:0] = 4'd13;
				else if (r < 90) d[3:0] = 4'd0;
				else             d[3:0] = 4'($urandom_range(14, 15));
				write_reg(CFG_CHANNEL_COUNT, d);
			end
			if ($urandom_range(0, 1) == 1) begin
				r = $urandom_range(0, 9);
				if (r == 0)      d = {CFG_DATA_W{1'b1}};
				else if (r == 1) d = '0;
				else             d = wide_random();
				write_reg(CFG_CHANNEL_MAP, d);
			end
			if ($urandom_range(0, 1) == 1) begin
				d = ($urandom_range(0, 3) == 0) ? wide_random() : '0;
				r = $urandom_range(0, 9);
				if (r == 0)      d[7:0] = 8'hFF;
				else if (r == 1) d[7:0] = 8'h00;
				else             d[7:0] = 8'($urandom);
				write_reg(CFG_WRITE_COMMAND, d);
			end
			if ($urandom_range(0, 1) == 1) begin
				d = ($urandom_range(0, 3) == 0) ? wide_random() : '0;
				d[5:0] = 6'($urandom);
				write_reg(CFG_REGISTER_BASE, d);
			end
			// writes to indexes with no register behind them
			if ($urandom_range(0, 9) == 0)
				write_reg(CFG_SPARE_FIRST + 3'($urandom_range(0, 2)), wide_random());
			if (!play_on || $urandom_range(0, 2) != 0) begin
				if (play_on) send_item(OP_STOP, 10'($urandom), 16'($urandom));
				fill_table();
			end
			repeat ($urandom_range(10, 40)) play_step();
		end
	endtask

	// closing stretch with no idle cycles and the widest tick
	task automatic test_back_to_back();
		int unsigned goal;
		settle_block();
		gaps_on = 1'b0;
		write_reg(CFG_POINT_COUNT, 52'($urandom_range(1, 8)));
		write_reg(CFG_CHANNEL_COUNT, 52'd13);
		write_reg(CFG_CHANNEL_MAP, wide_random());
		if (play_on) send_item(OP_STOP, 10'($urandom), 16'($urandom));
		fill_table();
		goal = acted_items + 60;
		while (acted_items < goal) play_step();
	endtask

	initial begin
		// everything driven to a known value from time zero
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		mism_cnt    = 0;
		acted_items = 0;
		cycle_cnt   = 0;
		gaps_on     = 1'b1;

		// mirror starts from the reset state; the table is unknown
		pt_idx     = 0;
		play_on    = 1'b0;
		xfer_busy  = 1'b0;
		n_samples  = '0;
		n_errors   = '0;
		reg_points = POINT_COUNT_RST;
		reg_chans  = CHANNEL_COUNT_RST;
		reg_map    = '0;
		reg_wcmd   = '0;
		reg_base   = REGISTER_BASE_RST;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_registers();
		test_register_extremes();
		test_small_config();
		test_random_playback();
		test_back_to_back();

		// drain, then leave room for any stray strobe
		settle_block();
		repeat (16) @(posedge clk);
		if (mism_cnt == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- multichannel_dac_table_player_core.f -----
design/mdtp_pkg.sv
design/mdtp_ctrl.sv
design/mdtp_dpath.sv
design/multichannel_dac_table_player_core.sv
tb/tb_top.sv
